>>> hdl/keypad_debounce_scanner_core_macros.svh
// Assertion macros shared by the keypad debounce scanner RTL.
`ifndef KEYPAD_DEBOUNCE_SCANNER_CORE_MACROS_SVH
`define KEYPAD_DEBOUNCE_SCANNER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is held.
`define KDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("kds assertion failed");
// Clocked check that also holds during reset.
`define KDS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("kds assertion failed");
`else
`define KDS_ASSERT(lbl, clk, rstn, prop)
`define KDS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hdl/kds_pkg.sv
// Types and constants of the keypad debounce scanner.
package kds_pkg;

  localparam logic [7:0] NIBBLE_MASK = 8'h0F;
  localparam logic [7:0] BYTE_MASK   = 8'hFF;
  localparam int unsigned STROBE_IDX = 4;   // bit 4, mask 0x10
  localparam int unsigned KEY_BITS   = 7;   // bits below 0x80 are keys

  typedef enum logic [1:0] {
    OP_SCAN   = 2'd0,
    OP_LATCH  = 2'd1,
    OP_REARM  = 2'd2,
    OP_IGNORE = 2'd3
  } kds_op_t;

  typedef enum logic [1:0] {
    REG_PORT_MODE   = 2'd0,
    REG_PRESS_LIMIT = 2'd1,
    REG_REPEAT_NEED = 2'd2
  } kds_reg_t;

  typedef struct packed {
    logic       port_mode;
    logic [3:0] press_limit;
    logic [7:0] repeat_need;
  } kds_cfg_t;

  localparam kds_cfg_t CFG_RESET = '{port_mode: 1'b0, press_limit: 4'd1, repeat_need: 8'd3};

  typedef struct packed {
    kds_op_t    op;
    logic       eight;
    logic [7:0] code;
    logic [2:0] nkeys;
  } kds_item_t;

endpackage

>>> hdl/kds_cfg.sv
// Configuration register file of the keypad debounce scanner.
module kds_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output kds_pkg::kds_cfg_t  cfg
);
  import kds_pkg::*;

  kds_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_PORT_MODE:   cfg_nxt.port_mode   = cfg_data[0];
        REG_PRESS_LIMIT: cfg_nxt.press_limit = cfg_data[3:0];
        REG_REPEAT_NEED: cfg_nxt.repeat_need = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> hdl/kds_front.sv
// Front end: accepts input items, decodes the action and forms code and key count.
module kds_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [7:0]        in_port_sample,
  input  kds_pkg::kds_cfg_t cfg,
  input  logic              q_ready,
  output logic              q_push,
  output kds_pkg::kds_item_t q_item
);
  import kds_pkg::*;

  logic [7:0] code;
  logic [2:0] nkeys;

  always_comb begin
    if (cfg.port_mode) begin
      code = ~in_port_sample & BYTE_MASK;
    end else begin
      code = ~in_port_sample & NIBBLE_MASK;
    end
    // nibble mode leaves bits 4..6 clear, so one count covers both modes
    nkeys = '0;
    for (int b = 0; b < KEY_BITS; b++) begin
      nkeys = nkeys + {2'b00, code[b]};
    end
  end

  assign in_stall = !q_ready;
  assign q_push   = in_valid && q_ready;

  always_comb begin
    q_item.op    = kds_op_t'(in_action);
    q_item.eight = cfg.port_mode;
    q_item.code  = code;
    q_item.nkeys = nkeys;
  end

endmodule

>>> hdl/kds_fifo.sv
// Short queue of decoded items between front and back end.
`include "keypad_debounce_scanner_core_macros.svh"
module kds_fifo #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  kds_pkg::kds_item_t push_item,
  output logic               ready,
  output logic               valid,
  input  logic               pop,
  output kds_pkg::kds_item_t pop_item
);
  import kds_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  kds_item_t       mem_r [DEPTH];
  logic [AW-1:0]   wptr_r, wptr_nxt;
  logic [AW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign ready    = cnt_r != CW'(DEPTH);
  assign valid    = cnt_r != '0;
  assign pop_item = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  `KDS_ASSERT(a_fill_up, clk, rst_n, (push && !pop) |=> (cnt_r == $past(cnt_r) + CW'(1)))
  `KDS_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> valid)

endmodule

>>> hdl/kds_back.sv
// Back end: debounce state, press/release detection and the result register.
`include "keypad_debounce_scanner_core_macros.svh"
module kds_back (
  input  logic               clk,
  input  logic               rst_n,
  input  kds_pkg::kds_cfg_t  cfg,
  input  logic               q_valid,
  input  kds_pkg::kds_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_key_event,
  output logic [7:0]         out_key_code,
  output logic [7:0]         out_head_code,
  output logic [2:0]         out_pressed_count,
  output logic               out_siren_strobe
);
  import kds_pkg::*;

  logic [7:0] last_r, last_nxt;
  logic [7:0] rep_r, rep_nxt;
  logic       armed_r, armed_nxt;
  logic [7:0] head_r, head_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       strobe_r, strobe_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       event_r, event_nxt;
  logic       hit;

  assign q_pop = q_valid && (!ovalid_r || !out_stall);

  always_comb begin
    last_nxt   = last_r;
    rep_nxt    = rep_r;
    armed_nxt  = armed_r;
    head_nxt   = head_r;
    prev_nxt   = prev_r;
    strobe_nxt = strobe_r;
    cnt_nxt    = cnt_r;
    event_nxt  = event_r;
    ovalid_nxt = ovalid_r && out_stall;
    hit = armed_r && ({1'b0, q_item.nkeys} <= cfg.press_limit) && (q_item.code == last_r);
    if (q_pop) begin
      ovalid_nxt = 1'b1;
      event_nxt  = 1'b0;
      unique case (q_item.op)
        OP_SCAN: begin
          if (q_item.eight) begin
            strobe_nxt = !q_item.code[STROBE_IDX] && prev_r[STROBE_IDX];
            prev_nxt   = q_item.code;
          end
          priority if (q_item.nkeys != '0) begin
            if (!hit) begin
              rep_nxt = 8'd1;
            end else if (rep_r >= cfg.repeat_need) begin
              armed_nxt = 1'b0;
              event_nxt = 1'b1;
            end else begin
              rep_nxt = rep_r + 8'd1;
            end
          end else if (last_r != '0) begin
            rep_nxt = 8'd1;
          end else if (rep_r >= cfg.repeat_need) begin
            armed_nxt = 1'b1;
            event_nxt = head_r != '0;
          end else begin
            rep_nxt = rep_r + 8'd1;
          end
          last_nxt = q_item.code;
          cnt_nxt  = q_item.nkeys;
        end
        OP_LATCH:  head_nxt = last_r;
        OP_REARM:  armed_nxt = 1'b1;
        OP_IGNORE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      rep_r    <= '0;
      armed_r  <= 1'b0;
      head_r   <= '0;
      prev_r   <= '0;
      strobe_r <= 1'b0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
      event_r  <= 1'b0;
    end else begin
      last_r   <= last_nxt;
      rep_r    <= rep_nxt;
      armed_r  <= armed_nxt;
      head_r   <= head_nxt;
      prev_r   <= prev_nxt;
      strobe_r <= strobe_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      event_r  <= event_nxt;
    end
  end

  // state only moves on a pop, so the result fields read the state directly
  assign out_valid         = ovalid_r;
  assign out_key_event     = event_r;
  assign out_key_code      = last_r;
  assign out_head_code     = head_r;
  assign out_pressed_count = cnt_r;
  assign out_siren_strobe  = strobe_r;

  `KDS_ASSERT(a_quiet_ops, clk, rst_n, (q_pop && q_item.op != OP_SCAN) |=> !event_r)
  `KDS_ASSERT(a_rearm, clk, rst_n, (q_pop && q_item.op == OP_REARM) |=> armed_r)
  `KDS_ASSERT_ALWAYS(a_press_disarms, clk, (rst_n && q_pop && q_item.op == OP_SCAN && event_nxt && q_item.nkeys != '0) |=> !armed_r)

endmodule

>>> hdl/keypad_debounce_scanner_core.sv
// Top level of the keypad debounce scanner.
// Takes one item (scan, head latch, forced re-arm or ignore) per clock while in_stall is low
// and returns one result per item; sustained rate is one item per cycle while out_stall is
// low. An accepted item is decoded combinationally by the front end and written into the
// QUEUE_DEPTH-entry queue, then popped by the debounce back end, whose single state update
// per item registers the result and sets the rate. The queue absorbs output stalls so input
// transfers continue until it is full. Configuration writes are always ready.
module keypad_debounce_scanner_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_port_sample,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_key_event,
  output logic [7:0] out_key_code,
  output logic [7:0] out_head_code,
  output logic [2:0] out_pressed_count,
  output logic       out_siren_strobe,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import kds_pkg::*;

  kds_cfg_t  cfg;
  kds_item_t push_item;
  kds_item_t pop_item;
  logic      q_push, q_ready, q_valid, q_pop;

  kds_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kds_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_port_sample (in_port_sample),
    .cfg            (cfg),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  kds_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .ready     (q_ready),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_item  (pop_item)
  );

  kds_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .q_valid           (q_valid),
    .q_item            (pop_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_key_event     (out_key_event),
    .out_key_code      (out_key_code),
    .out_head_code     (out_head_code),
    .out_pressed_count (out_pressed_count),
    .out_siren_strobe  (out_siren_strobe)
  );

endmodule
